@@ src/rgb_pwm_with_random_fade_unit_assert.svh @@
// assertion macros for the rgb pwm fade unit
// used by rgb_pwm_with_random_fade_unit; no other dependencies
`ifndef RGB_PWM_WITH_RANDOM_FADE_UNIT_ASSERT_SVH
`define RGB_PWM_WITH_RANDOM_FADE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RPWM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb pwm fade unit: same-cycle check failed");

// next-cycle implication
`define RPWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb pwm fade unit: next-cycle check failed");

`else

`define RPWM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RPWM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/rgbpwm_pkg.sv @@
// types and constants for the rgb pwm fade unit
// no dependencies
package rgbpwm_pkg;

  localparam int NCH = 3;

  typedef logic [7:0] duty_t;
  typedef logic [1:0] cfg_idx_t;

  // on-phase end is PERIOD_TOP minus duty, modulo 256
  localparam duty_t PERIOD_TOP = 8'd254;

  // opcodes
  localparam logic OP_PWM  = 1'b0;
  localparam logic OP_ANIM = 1'b1;

  // configuration register indexes
  localparam cfg_idx_t CFG_RED_STEP   = 2'd0;
  localparam cfg_idx_t CFG_GREEN_STEP = 2'd1;
  localparam cfg_idx_t CFG_BLUE_STEP  = 2'd2;

  // one result word: index 0 red, 1 green, 2 blue
  typedef struct packed {
    logic [NCH-1:0]        level;
    logic [NCH-1:0][7:0]   duty;
  } res_t;

endpackage

@@ src/rgb_pwm_with_random_fade_unit.sv @@
// three-channel pwm with random fade, top level
// depends on rgbpwm_pkg and rgb_pwm_with_random_fade_unit_assert.svh
// an accepted word goes to out_r, or to the skid entry if the main word waits
// throughput: one word per cycle; a two-entry output stage (register + skid)
// keeps taking words while the consumer stalls for one word's worth
// reset (rst_n low, synchronous): counters, ends, levels, duties, targets zero,
// steps one, output stage empty
module rgb_pwm_with_random_fade_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  rgbpwm_pkg::cfg_idx_t  cfg_index,
  input  rgbpwm_pkg::duty_t     cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  rgbpwm_pkg::duty_t     in_random_red,
  input  rgbpwm_pkg::duty_t     in_random_green,
  input  rgbpwm_pkg::duty_t     in_random_blue,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_red_level,
  output logic                  out_green_level,
  output logic                  out_blue_level,
  output rgbpwm_pkg::duty_t     out_red_duty,
  output rgbpwm_pkg::duty_t     out_green_duty,
  output rgbpwm_pkg::duty_t     out_blue_duty
);

  import rgbpwm_pkg::*;

  `include "rgb_pwm_with_random_fade_unit_assert.svh"

  // per-channel state
  duty_t            cnt_r  [NCH];
  duty_t            cnt_nxt[NCH];
  duty_t            end_r  [NCH];
  duty_t            end_nxt[NCH];
  logic [NCH-1:0]   level_r;
  logic [NCH-1:0]   level_nxt;
  duty_t            duty_r  [NCH];
  duty_t            duty_nxt[NCH];
  duty_t            tgt_r  [NCH];
  duty_t            tgt_nxt[NCH];
  duty_t            step_r [NCH];

  duty_t            cnt_inc[NCH];
  duty_t            rnd    [NCH];

  // output stage: main register plus skid entry
  res_t             res_nxt;
  res_t             out_r;
  res_t             skid_r;
  logic             out_valid_r;
  logic             skid_valid_r;

  logic             in_acc;
  logic             out_fire;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  assign rnd[0] = in_random_red;
  assign rnd[1] = in_random_green;
  assign rnd[2] = in_random_blue;

  // step registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        step_r[c] <= 8'd1;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RED_STEP:   step_r[0] <= cfg_data;
        CFG_GREEN_STEP: step_r[1] <= cfg_data;
        CFG_BLUE_STEP:  step_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state for one word, channels are independent
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      cnt_nxt[c]   = cnt_r[c];
      end_nxt[c]   = end_r[c];
      level_nxt[c] = level_r[c];
      duty_nxt[c]  = duty_r[c];
      tgt_nxt[c]   = tgt_r[c];
      cnt_inc[c]   = cnt_r[c] + 8'd1;
      if (in_opcode == OP_PWM) begin
        // pwm tick: count, and on passing the end start the other phase
        cnt_nxt[c] = cnt_inc[c];
        if (cnt_inc[c] > end_r[c]) begin
          // off phase ends at duty, on phase at top minus duty (wraps)
          end_nxt[c]   = level_r[c] ? duty_r[c] : PERIOD_TOP - duty_r[c];
          level_nxt[c] = ~level_r[c];
          cnt_nxt[c]   = 8'd0;
        end
      end else begin
        // animation tick: walk toward target, new target once on it
        if (tgt_r[c] > duty_r[c]) begin
          duty_nxt[c] = duty_r[c] + step_r[c];
        end else if (tgt_r[c] < duty_r[c]) begin
          duty_nxt[c] = duty_r[c] - step_r[c];
        end else begin
          tgt_nxt[c] = rnd[c];
        end
      end
    end
  end

  always_comb begin
    res_nxt.level = level_nxt;
    for (int c = 0; c < NCH; c++) begin
      res_nxt.duty[c] = duty_nxt[c];
    end
  end

  // state update on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      for (int c = 0; c < NCH; c++) begin
        cnt_r[c]  <= 8'd0;
        end_r[c]  <= 8'd0;
        duty_r[c] <= 8'd0;
        tgt_r[c]  <= 8'd0;
      end
    end else if (in_acc) begin
      level_r <= level_nxt;
      for (int c = 0; c < NCH; c++) begin
        cnt_r[c]  <= cnt_nxt[c];
        end_r[c]  <= end_nxt[c];
        duty_r[c] <= duty_nxt[c];
        tgt_r[c]  <= tgt_nxt[c];
      end
    end
  end

  // output handshake control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // input is stalled; drain skid into the main register
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_acc) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = out_r.level[0];
  assign out_green_level = out_r.level[1];
  assign out_blue_level  = out_r.level[2];
  assign out_red_duty    = out_r.duty[0];
  assign out_green_duty  = out_r.duty[1];
  assign out_blue_duty   = out_r.duty[2];

  // skid holds a word only behind a waiting main word
  `RPWM_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  // a taken main word lets the skid drain
  `RPWM_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_r && !out_stall, !skid_valid_r)
  // pwm ticks never move duties
  `RPWM_ASSERT_NEXT(a_pwm_keeps_duty, clk, rst_n, in_acc && in_opcode == OP_PWM,
    duty_r[0] == $past(duty_r[0]) && duty_r[1] == $past(duty_r[1]) && duty_r[2] == $past(duty_r[2]))
  // animation ticks never touch levels
  `RPWM_ASSERT_NEXT(a_anim_keeps_level, clk, rst_n, in_acc && in_opcode == OP_ANIM,
    level_r == $past(level_r))

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for rgb_pwm_with_random_fade_unit: directed and random
// pwm and animation ticks, with a predictor kept in a small scoreboard class
// depends on rgbpwm_pkg and the unit's rtl
module tb;
  import rgbpwm_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int WORDS_PER_PHASE = 250;
  localparam int RANDOM_PHASES   = 8;
  // idle cycles waited after the last expected result has been seen
  localparam int SETTLE_CYCLES   = 4;

  // one input word as the sender sees it
  typedef struct packed {
    logic  op;
    duty_t red;
    duty_t green;
    duty_t blue;
  } fade_word_t;

  // predicts levels and duties of all three channels and holds the expected
  // result words in arrival order
  class fade_scoreboard;
    duty_t step [NCH];
    duty_t phase_count [NCH];
    duty_t phase_end [NCH];
    logic  level [NCH];
    duty_t duty [NCH];
    duty_t target [NCH];
    string chan_name [NCH];
    res_t  expected_q [$];
    int    errors;
    int    results_seen;

    function new();
      for (int c = 0; c < NCH; c++) begin
        step[c]        = 8'd1;
        phase_count[c] = '0;
        phase_end[c]   = '0;
        level[c]       = 1'b0;
        duty[c]        = '0;
        target[c]      = '0;
      end
      chan_name[0] = "red";
      chan_name[1] = "green";
      chan_name[2] = "blue";
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_step(cfg_idx_t idx, duty_t value);
      case (idx)
        CFG_RED_STEP:   step[0] = value;
        CFG_GREEN_STEP: step[1] = value;
        CFG_BLUE_STEP:  step[2] = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // advance the channel state by one accepted word and queue its result
    function void note_word(fade_word_t w);
      duty_t rnd [NCH];
      res_t  r;
      rnd[0] = w.red;
      rnd[1] = w.green;
      rnd[2] = w.blue;
      if (w.op == OP_PWM) begin
        for (int c = 0; c < NCH; c++) begin
          phase_count[c] = phase_count[c] + 8'd1;
          if (phase_count[c] > phase_end[c]) begin
            // off phase ends after duty, on phase after PERIOD_TOP - duty (wraps)
            phase_end[c]   = level[c] ? duty[c] : duty_t'(PERIOD_TOP - duty[c]);
            level[c]       = ~level[c];
            phase_count[c] = '0;
          end
        end
      end else begin
        for (int c = 0; c < NCH; c++) begin
          if (target[c] > duty[c])
            duty[c] = duty[c] + step[c];
          else if (target[c] < duty[c])
            duty[c] = duty[c] - step[c];
          else
            target[c] = rnd[c];
        end
      end
      for (int c = 0; c < NCH; c++) begin
        r.level[c] = level[c];
        r.duty[c]  = duty[c];
      end
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task check_result(res_t got);
      res_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result word with no input word pending");
        return;
      end
      want = expected_q.pop_front();
      for (int c = 0; c < NCH; c++) begin
        if (got.level[c] !== want.level[c])
          report_mismatch($sformatf("%s level got %0b expected %0b",
                                    chan_name[c], got.level[c], want.level[c]));
        if (got.duty[c] !== want.duty[c])
          report_mismatch($sformatf("%s duty got %0d expected %0d",
                                    chan_name[c], got.duty[c], want.duty[c]));
      end
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_RED_STEP;
  duty_t    cfg_data = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  logic     in_opcode = OP_PWM;
  duty_t    in_random_red = '0;
  duty_t    in_random_green = '0;
  duty_t    in_random_blue = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  logic     out_red_level;
  logic     out_green_level;
  logic     out_blue_level;
  duty_t    out_red_duty;
  duty_t    out_green_duty;
  duty_t    out_blue_duty;

  fade_scoreboard fade_board = new();
  fade_word_t     stim_q [$];
  int             in_idle_pct = 0;
  int             out_stall_pct = 0;
  int             words_sent = 0;
  int             step_settings = 1;
  int             cycle_count = 0;

  rgb_pwm_with_random_fade_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_random_red   (in_random_red),
    .in_random_green (in_random_green),
    .in_random_blue  (in_random_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_red_duty    (out_red_duty),
    .out_green_duty  (out_green_duty),
    .out_blue_duty   (out_blue_duty)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, fade_board.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle from the current stall rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // watch both channels; values here are the ones settled before the edge
  always @(posedge clk) begin : watch_channels
    res_t got;
    if (rst_n && in_valid && !in_stall)
      fade_board.note_word({in_opcode, in_random_red, in_random_green, in_random_blue});
    if (rst_n && out_valid && !out_stall) begin
      got.level[0] = out_red_level;
      got.level[1] = out_green_level;
      got.level[2] = out_blue_level;
      got.duty[0]  = out_red_duty;
      got.duty[1]  = out_green_duty;
      got.duty[2]  = out_blue_duty;
      fade_board.check_result(got);
    end
  end

  function automatic void push_word(logic op, duty_t red, duty_t green, duty_t blue);
    fade_word_t w;
    w.op    = op;
    w.red   = red;
    w.green = green;
    w.blue  = blue;
    stim_q.push_back(w);
  endfunction

  // mostly legal targets, now and then 254 or 255 which are taken as they are
  function automatic duty_t random_target();
    if ($urandom_range(9) == 0)
      return duty_t'($urandom_range(255, 254));
    return duty_t'($urandom_range(253));
  endfunction

  function automatic void queue_random(int count, int pwm_pct);
    for (int i = 0; i < count; i++)
      push_word(($urandom_range(99) < pwm_pct) ? OP_PWM : OP_ANIM,
                random_target(), random_target(), random_target());
  endfunction

  // feed every queued word; valid holds its word until the unit takes it
  task automatic send_queued();
    int issued;
    int taken;
    int total;
    issued = 0;
    taken  = 0;
    total  = stim_q.size();
    while (taken < total) begin
      @(posedge clk);
      if (in_valid && !in_stall)
        taken++;
      if (!in_valid || !in_stall) begin
        if (issued < total && $urandom_range(99) >= in_idle_pct) begin
          in_opcode       <= stim_q[issued].op;
          in_random_red   <= stim_q[issued].red;
          in_random_green <= stim_q[issued].green;
          in_random_blue  <= stim_q[issued].blue;
          in_valid        <= 1'b1;
          issued++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
    words_sent += total;
    stim_q.delete();
  endtask

  task automatic wait_drained();
    while (fade_board.pending() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(cfg_idx_t idx, duty_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    fade_board.set_step(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_steps(duty_t red, duty_t green, duty_t blue);
    write_step(CFG_RED_STEP, red);
    write_step(CFG_GREEN_STEP, green);
    write_step(CFG_BLUE_STEP, blue);
    step_settings++;
  endtask

  initial begin
    duty_t red_s;
    duty_t green_s;
    duty_t blue_s;
    int    pwm_pct;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset steps: every channel sits on target zero, so the first
    // animation tick loads targets, including the out-of-range 254 and 255
    push_word(OP_ANIM, 8'd255, 8'd254, 8'd253);
    push_word(OP_ANIM, 8'd0, 8'd0, 8'd0);
    push_word(OP_PWM, 8'd0, 8'd0, 8'd0);
    push_word(OP_PWM, 8'd255, 8'd255, 8'd255);
    push_word(OP_ANIM, 8'd1, 8'd128, 8'd127);
    push_word(OP_PWM, 8'd0, 8'd0, 8'd0);
    send_queued();
    wait_drained();

    // directed, extreme steps: full-scale step overshoots and wraps, zero
    // step freezes blue off its target
    set_steps(8'd255, 8'd254, 8'd0);
    push_word(OP_ANIM, 8'd0, 8'd0, 8'd0);
    push_word(OP_ANIM, 8'd85, 8'd170, 8'd255);
    push_word(OP_PWM, 8'd0, 8'd0, 8'd0);
    push_word(OP_PWM, 8'd0, 8'd0, 8'd0);
    push_word(OP_PWM, 8'd0, 8'd0, 8'd0);
    push_word(OP_ANIM, 8'd254, 8'd255, 8'd0);
    push_word(OP_ANIM, 8'd170, 8'd85, 8'd1);
    push_word(OP_PWM, 8'd0, 8'd0, 8'd0);
    push_word(OP_ANIM, 8'd0, 8'd0, 8'd0);
    push_word(OP_PWM, 8'd0, 8'd0, 8'd0);
    push_word(OP_ANIM, 8'd255, 8'd255, 8'd255);
    push_word(OP_PWM, 8'd0, 8'd0, 8'd0);
    push_word(OP_ANIM, 8'd253, 8'd253, 8'd253);
    push_word(OP_PWM, 8'd0, 8'd0, 8'd0);
    send_queued();
    wait_drained();

    // random phases: each picks a step setting, a pwm/animation mix and an
    // idling pattern; state carries over so long pwm runs reach the toggles
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin red_s = 8'd0;   green_s = 8'd255; blue_s = 8'd128; pwm_pct = 50; end
        1: begin red_s = 8'd255; green_s = 8'd0;   blue_s = 8'd1;   pwm_pct = 85; end
        2: begin red_s = 8'd1;   green_s = 8'd1;   blue_s = 8'd1;   pwm_pct = 95; end
        3: begin red_s = 8'd2;   green_s = 8'd7;   blue_s = 8'd13;  pwm_pct = 50; end
        5: begin red_s = 8'd3;   green_s = 8'd253; blue_s = 8'd254; pwm_pct = 95; end
        7: begin red_s = 8'd1;   green_s = 8'd2;   blue_s = 8'd255; pwm_pct = 85; end
        default: begin
          red_s   = duty_t'($urandom_range(255));
          green_s = duty_t'($urandom_range(255));
          blue_s  = duty_t'($urandom_range(255));
          pwm_pct = (phase == 4) ? 85 : 50;
        end
      endcase
      set_steps(red_s, green_s, blue_s);

      // no idling, sender gaps, receiver stalls, then a little of both
      case (phase % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 51; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 51; end
        default: begin in_idle_pct = 12; out_stall_pct = 12; end
      endcase

      queue_random(WORDS_PER_PHASE, pwm_pct);
      send_queued();
      wait_drained();
    end

    $display("sent %0d words under %0d step settings and four idling patterns",
             words_sent, step_settings);
    $display("compared %0d result words, %0d mismatches",
             fade_board.results_seen, fade_board.errors);
    if (fade_board.errors == 0 && fade_board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
